/* src/sfug_pkg.sv */
`default_nettype none

package sfug_pkg;

    // Fixed geometry
    localparam int          BLOCK_BYTES = 256;
    localparam logic [5:0]  LAST_INDEX  = 6'(BLOCK_BYTES / 4 - 1);
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

    // Register reset values
    localparam logic [31:0] APP_BASE_RST  = 32'd134234112;
    localparam logic [31:0] APP_LIMIT_RST = 32'd134479872;
    localparam logic [31:0] RAM_BASE_RST  = 32'd536870912;
    localparam logic [24:0] RAM_BYTES_RST = 25'd98304;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_APP_BASE  = 2'd0,
        CFG_APP_LIMIT = 2'd1,
        CFG_RAM_BASE  = 2'd2,
        CFG_RAM_BYTES = 2'd3
    } t_cfg_reg;

    // Flash operation codes
    typedef enum logic [1:0] {
        FOP_STATUS  = 2'd0,
        FOP_ERASE   = 2'd1,
        FOP_PROGRAM = 2'd2
    } t_flash_op;

    typedef struct packed {
        logic [31:0] app_base;
        logic [31:0] app_limit;
        logic [31:0] ram_base;
        logic [24:0] ram_bytes;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [31:0] word_address;
        logic [31:0] data_word;
        logic        block_first;
        logic        block_last;
        logic [31:0] flash_word;
        logic [31:0] sp_slot_word;
        logic        erase_ok;
        logic        program_ok;
        logic        sp_program_ok;
    } t_item;

    // Update state, apart from the per-sector erased flags
    typedef struct packed {
        logic        started;
        logic        failed;
        logic        done;
        logic        vheld;
        logic        skip;
        logic        mism;
        logic [5:0]  idx;
        logic [31:0] block_start;
        logic [31:0] hw;
        logic [31:0] held_sp;
        logic [31:0] held_pc;
    } t_state;

    typedef struct packed {
        t_flash_op   op;
        logic [31:0] addr;
        logic [31:0] data;
    } t_slot;

endpackage

`default_nettype wire

/* src/sfug_if.sv */
`default_nettype none

// Input request channel
interface sfug_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] word_address;
    logic [31:0] data_word;
    logic        block_first;
    logic        block_last;
    logic [31:0] flash_word;
    logic [31:0] sp_slot_word;
    logic        erase_ok;
    logic        program_ok;
    logic        sp_program_ok;

    modport source (output valid, command, word_address, data_word, block_first,
                    block_last, flash_word, sp_slot_word, erase_ok, program_ok,
                    sp_program_ok, input ready);
    modport sink   (input valid, command, word_address, data_word, block_first,
                    block_last, flash_word, sp_slot_word, erase_ok, program_ok,
                    sp_program_ok, output ready);
endinterface

// Result channel
interface sfug_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  flash_op;
    logic [31:0] op_address;
    logic [31:0] op_data;
    logic        accepted;
    logic        image_complete;
    logic        last_result;

    modport source (output valid, flash_op, op_address, op_data, accepted,
                    image_complete, last_result, input ready);
    modport sink   (input valid, flash_op, op_address, op_data, accepted,
                    image_complete, last_result, output ready);
endinterface

// Register write channel
interface sfug_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

/* src/sfug_eval.sv */
`default_nettype none

// One request against the current state: next state plus the flash ops it causes
module sfug_eval #(
    parameter int SECTOR_BYTES = 2048,
    parameter int SECTOR_COUNT = 128
) (
    input  var sfug_pkg::t_item         i_item,
    input  var sfug_pkg::t_state        i_state,
    input  var logic [SECTOR_COUNT-1:0] i_erased,
    input  var sfug_pkg::t_cfg          i_cfg,
    output sfug_pkg::t_state            o_state,
    output logic [SECTOR_COUNT-1:0]     o_erased,
    output logic [2:0]                  o_slot_v,
    output sfug_pkg::t_slot [2:0]       o_slots,
    output logic                        o_acc,
    output logic                        o_complete
);

    localparam int          SEC_W     = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int          SEC_SHIFT = $clog2(SECTOR_BYTES);
    localparam logic [31:0] SEC_MASK  = ~(32'(SECTOR_BYTES) - 32'd1);

    // Word path decode
    logic                    first_bad;
    logic [31:0]             bs;
    logic [5:0]              idx;
    logic                    mism;
    logic                    skip;
    logic [31:0]             target;
    logic [31:0]             off;
    logic                    in_range;
    logic [31:0]             sec_full;
    logic                    sec_ok;
    logic [SEC_W-1:0]        sec_idx;
    logic [SECTOR_COUNT-1:0] erased_sh;
    logic [SECTOR_COUNT-1:0] sec_onehot;
    logic                    need_e0;
    logic                    need_e1;
    logic                    len_bad;
    logic                    is_vec;
    logic [31:0]             held_sel;
    logic [32:0]             blk_end;

    // Flush checks
    logic [32:0]             ram_top;
    logic                    vec_bad;

    always_comb begin
        first_bad  = (i_item.word_address[7:0] != 8'd0)
                  || (i_item.word_address < i_cfg.app_base)
                  || (i_item.word_address >= i_cfg.app_limit)
                  || ((i_cfg.app_limit - i_item.word_address) < 32'(sfug_pkg::BLOCK_BYTES));
        bs         = i_item.block_first ? i_item.word_address : i_state.block_start;
        idx        = i_item.block_first ? 6'd0 : i_state.idx;
        mism       = i_item.block_first ? 1'b0 : i_state.mism;
        skip       = i_item.block_first ? first_bad : i_state.skip;
        target     = bs + {24'd0, idx, 2'b00};
        off        = target - i_cfg.app_base;
        in_range   = (target >= i_cfg.app_base) && (target < i_cfg.app_limit)
                  && ((i_cfg.app_limit - target) >= 32'd4);
        sec_full   = off >> SEC_SHIFT;
        sec_ok     = sec_full < 32'(SECTOR_COUNT);
        sec_idx    = sec_full[SEC_W-1:0];
        erased_sh  = i_erased >> sec_idx;
        sec_onehot = SECTOR_COUNT'(1) << sec_idx;
        need_e0    = !i_state.started;
        // sector 0 is covered by the first-use erase
        need_e1    = !(erased_sh[0] || (need_e0 && (sec_idx == '0)));
        len_bad    = i_item.block_last != (idx == sfug_pkg::LAST_INDEX);
        is_vec     = off < 32'd8;
        held_sel   = off[2] ? i_state.held_pc : i_state.held_sp;
        blk_end    = {1'b0, bs} + 33'(sfug_pkg::BLOCK_BYTES);

        ram_top    = {1'b0, i_cfg.ram_base} + {8'd0, i_cfg.ram_bytes};
        vec_bad    = !i_state.vheld
                  || (i_state.held_sp <= i_cfg.ram_base)
                  || ({1'b0, i_state.held_sp} > ram_top)
                  || (i_state.held_sp[2:0] != 3'd0)
                  || !i_state.held_pc[0]
                  || ({1'b0, i_state.held_pc} < ({1'b0, i_cfg.app_base} + 33'd8))
                  || (i_state.held_pc >= i_state.hw);
    end

    // Request evaluation
    logic fail;
    logic ok_pc;
    logic ok_sp;

    always_comb begin
        o_state    = i_state;
        o_erased   = i_erased;
        o_slot_v   = 3'b000;
        o_slots    = '{default: '{op: sfug_pkg::FOP_STATUS, addr: 32'd0, data: 32'd0}};
        o_acc      = 1'b0;
        fail       = 1'b0;
        ok_pc      = 1'b0;
        ok_sp      = 1'b0;

        if (!i_item.command) begin
            o_state.block_start = bs;
            o_state.idx         = idx;
            o_state.mism        = mism;
            o_state.skip        = skip;
            if (!skip && !i_state.failed) begin
                if (len_bad || !in_range || !sec_ok) begin
                    o_state.skip = 1'b1;
                end else if (i_state.done) begin
                    // image complete: compare only
                    if (i_item.flash_word != i_item.data_word) begin
                        o_state.mism = 1'b1;
                    end
                end else begin
                    o_state.started = 1'b1;
                    if (need_e0) begin
                        o_slot_v[0] = 1'b1;
                        o_slots[0]  = '{op: sfug_pkg::FOP_ERASE, addr: i_cfg.app_base,
                                        data: 32'd0};
                        if (!i_item.erase_ok) begin
                            fail = 1'b1;
                        end else begin
                            o_erased[0] = 1'b1;
                        end
                    end
                    if (!fail && need_e1) begin
                        o_slot_v[1] = 1'b1;
                        o_slots[1]  = '{op: sfug_pkg::FOP_ERASE,
                                        addr: i_cfg.app_base + (off & SEC_MASK), data: 32'd0};
                        if (!i_item.erase_ok) begin
                            fail = 1'b1;
                        end else begin
                            o_erased = o_erased | sec_onehot;
                        end
                    end
                    if (!fail) begin
                        if (is_vec) begin
                            // vector words are held back, later copies must match
                            if (i_state.vheld && (held_sel != i_item.data_word)) begin
                                fail = 1'b1;
                            end else if (off[2]) begin
                                o_state.held_pc = i_item.data_word;
                            end else begin
                                o_state.held_sp = i_item.data_word;
                            end
                        end else if (i_item.flash_word != i_item.data_word) begin
                            if (i_item.flash_word != sfug_pkg::ALL_ONES) begin
                                fail = 1'b1;
                            end else begin
                                o_slot_v[2] = 1'b1;
                                o_slots[2]  = '{op: sfug_pkg::FOP_PROGRAM, addr: target,
                                                data: i_item.data_word};
                                fail        = !i_item.program_ok;
                            end
                        end
                    end
                end
                if (fail) begin
                    o_state.failed = 1'b1;
                end
                if (!o_state.skip && !o_state.failed) begin
                    o_acc = !o_state.mism;
                    if (i_item.block_last) begin
                        if (!i_state.done) begin
                            if (bs == i_cfg.app_base) begin
                                o_state.vheld = 1'b1;
                            end
                            if (blk_end > {1'b0, i_state.hw} && !blk_end[32]) begin
                                o_state.hw = blk_end[31:0];
                            end
                        end
                        o_state.skip = 1'b1;
                    end else begin
                        o_state.idx = idx + 6'd1;
                    end
                end
            end
        end else begin
            // flush: check vectors, program PC then SP
            if (!(i_state.done || i_state.failed)) begin
                if (vec_bad) begin
                    o_state.failed = 1'b1;
                end else begin
                    if (i_item.flash_word == i_state.held_pc) begin
                        ok_pc = 1'b1;
                    end else if (i_item.flash_word == sfug_pkg::ALL_ONES) begin
                        o_slot_v[0] = 1'b1;
                        o_slots[0]  = '{op: sfug_pkg::FOP_PROGRAM,
                                        addr: i_cfg.app_base + 32'd4, data: i_state.held_pc};
                        ok_pc       = i_item.program_ok;
                    end
                    if (ok_pc) begin
                        if (i_item.sp_slot_word == i_state.held_sp) begin
                            ok_sp = 1'b1;
                        end else if (i_item.sp_slot_word == sfug_pkg::ALL_ONES) begin
                            o_slot_v[1] = 1'b1;
                            o_slots[1]  = '{op: sfug_pkg::FOP_PROGRAM, addr: i_cfg.app_base,
                                            data: i_state.held_sp};
                            ok_sp       = i_item.sp_program_ok;
                        end
                    end
                    o_state.done   = ok_pc && ok_sp;
                    o_state.failed = !(ok_pc && ok_sp);
                end
            end
            o_acc = !o_state.failed;
        end

        o_complete = o_state.done && !o_state.failed;
    end

endmodule

`default_nettype wire

/* src/safe_flash_update_guard.sv */
// Channel | Dir | Contents
// i_in    | in  | command, word_address, data_word, block_first/last, flash/sp slot words,
//         |     | erase_ok, program_ok, sp_program_ok
// o_out   | out | flash_op, op_address, op_data, accepted, image_complete, last_result
// i_cfg   | in  | reg_index, wr_data (app_base, app_limit, ram_base, ram_bytes)
//
// A request waits in the input register until the result buffer is free, is evaluated in
// one pass and its results (1 to 4) are loaded into the result buffer.
// The result buffer sends one result per cycle while o_out.ready is high.
// The next request is held in the input register while results drain.
// Reset is synchronous, active low; registers are writable at any time (ready is always high).
`default_nettype none

module safe_flash_update_guard #(
    parameter int SECTOR_BYTES = 2048,
    parameter int SECTOR_COUNT = 128
) (
    input  var logic   i_clk,
    input  var logic   i_rst_n,
    sfug_in_if.sink    i_in,
    sfug_out_if.source o_out,
    sfug_cfg_if.sink   i_cfg
);

    // Configuration registers
    sfug_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{app_base:  sfug_pkg::APP_BASE_RST,
                       app_limit: sfug_pkg::APP_LIMIT_RST,
                       ram_base:  sfug_pkg::RAM_BASE_RST,
                       ram_bytes: sfug_pkg::RAM_BYTES_RST};
        end else if (i_cfg.valid) begin
            unique case (sfug_pkg::t_cfg_reg'(i_cfg.reg_index))
                sfug_pkg::CFG_APP_BASE:  r_cfg.app_base  <= i_cfg.wr_data;
                sfug_pkg::CFG_APP_LIMIT: r_cfg.app_limit <= i_cfg.wr_data;
                sfug_pkg::CFG_RAM_BASE:  r_cfg.ram_base  <= i_cfg.wr_data;
                sfug_pkg::CFG_RAM_BYTES: r_cfg.ram_bytes <= i_cfg.wr_data[24:0];
                default: ;
            endcase
        end
    end

    // Handshake control
    logic                   r_in_vld;
    sfug_pkg::t_item        r_item;
    logic                   r_buf_vld;
    logic [2:0]             r_slot_v;
    sfug_pkg::t_slot [2:0]  r_slots;
    logic                   r_acc;
    logic                   r_cplt;
    logic                   out_fire;
    logic                   buf_free;
    logic                   load;
    logic                   in_fire;

    assign out_fire    = r_buf_vld && o_out.ready;
    assign buf_free    = !r_buf_vld || (out_fire && (r_slot_v == 3'b000));
    assign load        = r_in_vld && buf_free;
    assign i_in.ready  = !r_in_vld || load;
    assign in_fire     = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= '{command:       i_in.command,
                        word_address:  i_in.word_address,
                        data_word:     i_in.data_word,
                        block_first:   i_in.block_first,
                        block_last:    i_in.block_last,
                        flash_word:    i_in.flash_word,
                        sp_slot_word:  i_in.sp_slot_word,
                        erase_ok:      i_in.erase_ok,
                        program_ok:    i_in.program_ok,
                        sp_program_ok: i_in.sp_program_ok};
        end
    end

    // Update state
    sfug_pkg::t_state        r_st;
    logic [SECTOR_COUNT-1:0] r_erased;
    sfug_pkg::t_state        n_st;
    logic [SECTOR_COUNT-1:0] n_erased;
    logic [2:0]              n_slot_v;
    sfug_pkg::t_slot [2:0]   n_slots;
    logic                    n_acc;
    logic                    n_cplt;

    sfug_eval #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_eval (
        .i_item     (r_item),
        .i_state    (r_st),
        .i_erased   (r_erased),
        .i_cfg      (r_cfg),
        .o_state    (n_st),
        .o_erased   (n_erased),
        .o_slot_v   (n_slot_v),
        .o_slots    (n_slots),
        .o_acc      (n_acc),
        .o_complete (n_cplt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '{started: 1'b0, failed: 1'b0, done: 1'b0, vheld: 1'b0,
                          skip: 1'b0, mism: 1'b0, idx: 6'd0, block_start: 32'd0,
                          hw: sfug_pkg::APP_BASE_RST,
                          held_sp: sfug_pkg::ALL_ONES, held_pc: sfug_pkg::ALL_ONES};
            r_erased <= '0;
        end else if (load) begin
            r_st     <= n_st;
            r_erased <= n_erased;
        end
    end

    // Result buffer: pending flash ops, then the status result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
            r_slot_v  <= 3'b000;
        end else if (load) begin
            r_buf_vld <= 1'b1;
            r_slot_v  <= n_slot_v;
        end else if (out_fire) begin
            if (r_slot_v == 3'b000) begin
                r_buf_vld <= 1'b0;
            end else begin
                r_slot_v <= r_slot_v & (r_slot_v - 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slots <= n_slots;
            r_acc   <= n_acc;
            r_cplt  <= n_cplt;
        end
    end

    // Pick the oldest pending op
    sfug_pkg::t_slot cur;

    always_comb begin
        priority if (r_slot_v[0]) begin
            cur = r_slots[0];
        end else if (r_slot_v[1]) begin
            cur = r_slots[1];
        end else if (r_slot_v[2]) begin
            cur = r_slots[2];
        end else begin
            cur = '{op: sfug_pkg::FOP_STATUS, addr: 32'd0, data: 32'd0};
        end
    end

    assign o_out.valid          = r_buf_vld;
    assign o_out.flash_op       = cur.op;
    assign o_out.op_address     = cur.addr;
    assign o_out.op_data        = cur.data;
    assign o_out.accepted       = r_acc;
    assign o_out.image_complete = r_cplt;
    assign o_out.last_result    = (r_slot_v == 3'b000);

endmodule

`default_nettype wire

/* src/sfug_checker.sv */
`default_nettype none

module sfug_checker (
    input var logic        i_clk,
    input var logic        i_rst_n,
    input var logic        i_out_valid,
    input var logic        i_out_ready,
    input var logic [1:0]  i_flash_op,
    input var logic [31:0] i_op_address,
    input var logic [31:0] i_op_data,
    input var logic        i_accepted,
    input var logic        i_image_complete,
    input var logic        i_last_result
);

    logic       out_fire;
    logic       r_mid;
    logic       r_acc;
    logic       r_seen_cplt;
    logic [1:0] r_cnt;

    assign out_fire = i_out_valid && i_out_ready;

    // Track results within one request and completion history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_acc       <= 1'b0;
            r_seen_cplt <= 1'b0;
            r_cnt       <= 2'd0;
        end else if (out_fire) begin
            r_mid       <= !i_last_result;
            r_acc       <= i_accepted;
            r_seen_cplt <= r_seen_cplt || i_image_complete;
            r_cnt       <= i_last_result ? 2'd0 : r_cnt + 2'd1;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_flash_op)
            && $stable(i_op_address) && $stable(i_op_data) && $stable(i_last_result))
        else $error("result changed while stalled");

    // Completion is sticky
    a_cplt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_seen_cplt |-> i_image_complete)
        else $error("image_complete dropped after completion");

    // All results of one request carry the same accepted flag
    a_acc_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_mid |-> i_accepted == r_acc)
        else $error("accepted differs within one request");

    // At most four results per request
    a_max_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && (r_cnt == 2'd3) |-> i_last_result)
        else $error("more than four results for one request");

endmodule

bind safe_flash_update_guard sfug_checker u_sfug_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_flash_op       (o_out.flash_op),
    .i_op_address     (o_out.op_address),
    .i_op_data        (o_out.op_data),
    .i_accepted       (o_out.accepted),
    .i_image_complete (o_out.image_complete),
    .i_last_result    (o_out.last_result)
);

`default_nettype wire

/* tb/safe_flash_update_guard_tb.sv */
`timescale 1ns / 100ps

module safe_flash_update_guard_tb;

    localparam int unsigned SECTOR_BYTES = 2048;
    localparam int unsigned SECTOR_COUNT = 128;
    localparam int unsigned LIMIT_CYCLES = 200000;

    // One expected flash operation or status
    typedef struct {
        sfug_pkg::t_flash_op op;
        logic [31:0]         addr;
        logic [31:0]         data;
        logic                acc;
        logic                cmpl;
        logic                last;
    } t_flash_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfug_in_if  req_if ();
    sfug_out_if res_if ();
    sfug_cfg_if cfg_if ();

    safe_flash_update_guard #(
        .SECTOR_BYTES(SECTOR_BYTES),
        .SECTOR_COUNT(SECTOR_COUNT)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if),
        .i_cfg  (cfg_if)
    );

    // Shadow registers
    logic [31:0] region_lo = sfug_pkg::APP_BASE_RST;
    logic [31:0] region_hi = sfug_pkg::APP_LIMIT_RST;
    logic [31:0] ram_lo    = sfug_pkg::RAM_BASE_RST;
    logic [24:0] ram_size  = sfug_pkg::RAM_BYTES_RST;

    // Shadow update state
    logic [SECTOR_COUNT-1:0] erased_map = '0;
    logic [31:0] boot_sp        = sfug_pkg::ALL_ONES;
    logic [31:0] boot_pc        = sfug_pkg::ALL_ONES;
    bit          vectors_locked = 1'b0;
    bit          started        = 1'b0;
    bit          failed         = 1'b0;
    bit          complete       = 1'b0;
    logic [31:0] top_written    = sfug_pkg::APP_BASE_RST;
    bit          blk_closed     = 1'b0;
    bit          blk_differs    = 1'b0;
    logic [5:0]  blk_word       = '0;
    logic [31:0] blk_base       = '0;

    sfug_pkg::t_slot op_list[$];
    t_flash_result   flash_ops_due[$];
    t_flash_result   oldest_due;

    // Vector words of the image under test
    logic [31:0] image_sp;
    logic [31:0] image_pc;

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    bit          jitter_on = 1'b1;
    int          sink_hold = 0;
    int          sink_pause = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result sink: long hold-off on request, else random stall bursts
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            res_if.ready <= 1'b0;
        end else if (sink_pause != 0) begin
            sink_pause <= sink_pause - 1;
            res_if.ready <= 1'b0;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
            sink_pause <= $urandom_range(0, 7);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (flash_ops_due.size() == 0) begin
                $error("unexpected result: op %0d addr %0h", res_if.flash_op,
                       res_if.op_address);
                fail_count++;
            end else begin
                oldest_due = flash_ops_due.pop_front();
                check_field("flash_op", oldest_due.op, res_if.flash_op);
                check_field("op_address", oldest_due.addr, res_if.op_address);
                check_field("op_data", oldest_due.data, res_if.op_data);
                check_field("accepted", oldest_due.acc, res_if.accepted);
                check_field("image_complete", oldest_due.cmpl, res_if.image_complete);
                check_field("last_result", oldest_due.last, res_if.last_result);
            end
        end
    end

    // ---------------- predictor ----------------

    // Program only an erased word; identical content needs nothing
    function automatic bit burn_word(logic [31:0] addr, logic [31:0] word,
                                     logic [31:0] old, bit ok);
        if (old == word) return 1'b1;
        if (old != sfug_pkg::ALL_ONES) return 1'b0;
        op_list.push_back('{sfug_pkg::FOP_PROGRAM, addr, word});
        return ok;
    endfunction

    function automatic bit wipe_sector(logic [31:0] sec, bit ok);
        op_list.push_back('{sfug_pkg::FOP_ERASE, region_lo + sec * 32'(SECTOR_BYTES), 32'd0});
        if (!ok) begin
            failed = 1'b1;
            return 1'b0;
        end
        erased_map[sec] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void store_word(logic [31:0] target, logic [31:0] sec,
                                       logic [31:0] data, logic [31:0] old, bit eok, bit pok);
        logic [31:0] off;
        off = target - region_lo;
        // sector 0 goes first on the very first accepted word
        if (!started) begin
            started = 1'b1;
            if (!wipe_sector(32'd0, eok)) return;
        end
        if (!erased_map[sec] && !wipe_sector(sec, eok)) return;
        if (off < 32'd8) begin
            if (off[2]) begin
                if (vectors_locked && boot_pc != data) begin
                    failed = 1'b1;
                    return;
                end
                boot_pc = data;
            end else begin
                if (vectors_locked && boot_sp != data) begin
                    failed = 1'b1;
                    return;
                end
                boot_sp = data;
            end
        end else if (!burn_word(target, data, old, pok)) begin
            failed = 1'b1;
        end
    endfunction

    // Check the held vectors, then program PC and after it SP
    function automatic void commit_vectors(logic [31:0] pc_old, logic [31:0] sp_old,
                                           bit pok, bit spok);
        logic [32:0] ram_top;
        ram_top = {1'b0, ram_lo} + 33'(ram_size);
        if (complete || failed) return;
        if (!vectors_locked || boot_sp <= ram_lo || {1'b0, boot_sp} > ram_top ||
            boot_sp[2:0] != 3'd0 || !boot_pc[0] ||
            {1'b0, boot_pc} < {1'b0, region_lo} + 33'd8 || boot_pc >= top_written) begin
            failed = 1'b1;
            return;
        end
        if (burn_word(region_lo + 32'd4, boot_pc, pc_old, pok))
            complete = burn_word(region_lo, boot_sp, sp_old, spok);
        else
            complete = 1'b0;
        failed = !complete;
    endfunction

    function automatic void predict_flash_ops(sfug_pkg::t_item it);
        bit          acc;
        bit          in_range;
        logic [31:0] target;
        logic [31:0] sec;
        logic [32:0] blk_end;
        t_flash_result r;
        acc = 1'b0;
        op_list.delete();
        if (it.command) begin
            commit_vectors(it.flash_word, it.sp_slot_word, it.program_ok, it.sp_program_ok);
            acc = !failed;
        end else begin
            if (it.block_first) begin
                blk_base    = it.word_address;
                blk_word    = '0;
                blk_differs = 1'b0;
                blk_closed  = it.word_address[7:0] != 8'd0 || it.word_address < region_lo ||
                              it.word_address >= region_hi ||
                              region_hi - it.word_address < 32'(sfug_pkg::BLOCK_BYTES);
            end
            if (!blk_closed && !failed) begin
                target   = blk_base + {24'd0, blk_word, 2'b00};
                in_range = target >= region_lo && target < region_hi &&
                           region_hi - target >= 32'd4;
                sec      = in_range ? (target - region_lo) / 32'(SECTOR_BYTES) : 32'd0;
                if (it.block_last != (blk_word == sfug_pkg::LAST_INDEX))
                    blk_closed = 1'b1;
                else if (!in_range || sec >= 32'(SECTOR_COUNT))
                    blk_closed = 1'b1;
                else if (complete) begin
                    if (it.flash_word != it.data_word) blk_differs = 1'b1;
                end else
                    store_word(target, sec, it.data_word, it.flash_word, it.erase_ok,
                               it.program_ok);

                if (!blk_closed && !failed) begin
                    acc = !blk_differs;
                    if (it.block_last) begin
                        if (!complete) begin
                            blk_end = {1'b0, blk_base} + 33'(sfug_pkg::BLOCK_BYTES);
                            if (blk_base == region_lo) vectors_locked = 1'b1;
                            if (blk_end > {1'b0, top_written} &&
                                blk_end <= {1'b0, sfug_pkg::ALL_ONES})
                                top_written = blk_end[31:0];
                        end
                        blk_closed = 1'b1;
                    end else begin
                        blk_word = blk_word + 6'd1;
                    end
                end
            end
        end
        op_list.push_back('{sfug_pkg::FOP_STATUS, 32'd0, 32'd0});
        foreach (op_list[k]) begin
            r.op   = op_list[k].op;
            r.addr = op_list[k].addr;
            r.data = op_list[k].data;
            r.acc  = acc;
            r.cmpl = complete && !failed;
            r.last = (k == op_list.size() - 1);
            flash_ops_due.push_back(r);
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return sfug_pkg::ALL_ONES;
            default: return $urandom();
        endcase
    endfunction

    function automatic sfug_pkg::t_item random_item();
        sfug_pkg::t_item it;
        it.command       = 1'($urandom_range(0, 1));
        it.word_address  = $urandom();
        it.data_word     = pick_data();
        it.block_first   = 1'($urandom_range(0, 1));
        it.block_last    = 1'($urandom_range(0, 1));
        it.flash_word    = pick_data();
        it.sp_slot_word  = pick_data();
        it.erase_ok      = 1'($urandom_range(0, 1));
        it.program_ok    = 1'($urandom_range(0, 1));
        it.sp_program_ok = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Random 256-byte aligned block inside the region, skipping the first lo_blk blocks
    function automatic logic [31:0] region_block(int unsigned lo_blk);
        int unsigned n_blk;
        n_blk = (region_hi - region_lo) / sfug_pkg::BLOCK_BYTES;
        return region_lo + 32'(sfug_pkg::BLOCK_BYTES) * $urandom_range(lo_blk, n_blk - 1);
    endfunction

    // Send one request, hold valid until it is taken, then predict its results
    task automatic send_request(input sfug_pkg::t_item it);
        int gap;
        gap = 0;
        if (jitter_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= it.command;
        req_if.word_address  <= it.word_address;
        req_if.data_word     <= it.data_word;
        req_if.block_first   <= it.block_first;
        req_if.block_last    <= it.block_last;
        req_if.flash_word    <= it.flash_word;
        req_if.sp_slot_word  <= it.sp_slot_word;
        req_if.erase_ok      <= it.erase_ok;
        req_if.program_ok    <= it.program_ok;
        req_if.sp_program_ok <= it.sp_program_ok;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_flash_ops(it);
    endtask

    // Words of one block; last mark on word last_at (none if out of range).
    // Update mode keeps flash erased or identical; compare mode is free-form
    // with one flush in the middle.
    task automatic send_block(input logic [31:0] base, input int nwords, input int last_at,
                              input bit cmp_mode);
        sfug_pkg::t_item it;
        int              k;
        int              mid_flush;
        mid_flush = cmp_mode ? $urandom_range(1, nwords - 1) : -1;
        for (k = 0; k < nwords; k++) begin
            it = random_item();
            it.command     = 1'b0;
            it.block_first = (k == 0);
            it.block_last  = (k == last_at);
            if (k == 0) it.word_address = base;
            if (cmp_mode) begin
                if ($urandom_range(0, 3) != 0) it.flash_word = it.data_word;
            end else begin
                if (base == region_lo && k < 2) it.data_word = (k == 0) ? image_sp : image_pc;
                it.flash_word = ($urandom_range(0, 3) == 0) ? it.data_word : sfug_pkg::ALL_ONES;
                it.erase_ok   = 1'b1;
                it.program_ok = 1'b1;
            end
            send_request(it);
            if (k == mid_flush) begin
                it = random_item();
                it.command = 1'b1;
                send_request(it);
            end
        end
    endtask

    // Stray requests while no block is open
    task automatic send_noise(input int n, input bit cmp_mode);
        sfug_pkg::t_item it;
        repeat (n) begin
            it = random_item();
            it.block_first = ($urandom_range(0, 2) == 0);
            if (!cmp_mode) begin
                it.command = 1'b0;
                if (it.word_address[7:0] == 8'd0) it.word_address[0] = 1'b1;
            end
            send_request(it);
        end
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (flash_ops_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input sfug_pkg::t_cfg_reg idx, input logic [31:0] value);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            sfug_pkg::CFG_APP_BASE:  region_lo = value;
            sfug_pkg::CFG_APP_LIMIT: region_hi = value;
            sfug_pkg::CFG_RAM_BASE:  ram_lo    = value;
            sfug_pkg::CFG_RAM_BYTES: ram_size  = value[24:0];
        endcase
        @(posedge i_clk);
    endtask

    // ---------------- tests ----------------

    // Misaligned, below and above the region; stray words stay skipped
    task automatic test_block_rejects();
        send_block(region_lo + 32'd4, 1, -1, 1'b0);
        send_noise(2, 1'b0);
        send_block(region_lo - 32'd256, 1, -1, 1'b0);
        send_block(region_hi, 1, -1, 1'b0);
    endtask

    // Early last marks; the second block erases sectors 0 and 1 on its first word
    task automatic test_wrong_length();
        send_block(region_lo + 32'(SECTOR_BYTES), 1, 0, 1'b0);
        send_block(region_lo + 32'(SECTOR_BYTES), 4, 3, 1'b0);
        send_noise(1, 1'b0);
        wait_drain();
    endtask

    // Region bounds at their extremes
    task automatic test_config_extremes();
        write_reg(sfug_pkg::CFG_APP_BASE, 32'd0);
        write_reg(sfug_pkg::CFG_APP_LIMIT, sfug_pkg::ALL_ONES);
        write_reg(sfug_pkg::CFG_RAM_BASE, sfug_pkg::ALL_ONES);
        write_reg(sfug_pkg::CFG_RAM_BYTES, 32'd0);
        send_block(32'hffff_ff00, 1, -1, 1'b0);              // runs past the limit
        send_block(32'(SECTOR_COUNT * SECTOR_BYTES), 1, -1, 1'b0);  // sector too high
        send_block(32'(SECTOR_COUNT * SECTOR_BYTES) - 32'd256, 2, 1, 1'b0);
        wait_drain();
        write_reg(sfug_pkg::CFG_APP_LIMIT, 32'h0000_01f0);
        send_block(32'h0000_0100, 1, -1, 1'b0);              // block crosses the limit
        send_block(32'h0000_0000, 3, 2, 1'b0);               // vector words held, no lock
        wait_drain();
        write_reg(sfug_pkg::CFG_APP_LIMIT, 32'd0);
        send_block(32'h0000_0000, 1, -1, 1'b0);
        wait_drain();
        write_reg(sfug_pkg::CFG_APP_BASE, sfug_pkg::ALL_ONES);
        send_block(32'hffff_ff00, 1, -1, 1'b0);
        wait_drain();
    endtask

    // Full image: vector block, stray and short blocks, a block under
    // receiver back-pressure, then the commit flush
    task automatic test_image_update();
        sfug_pkg::t_item it;
        int              n;
        write_reg(sfug_pkg::CFG_APP_BASE, sfug_pkg::APP_BASE_RST);
        write_reg(sfug_pkg::CFG_APP_LIMIT, sfug_pkg::APP_LIMIT_RST);
        write_reg(sfug_pkg::CFG_RAM_BASE, sfug_pkg::RAM_BASE_RST);
        write_reg(sfug_pkg::CFG_RAM_BYTES, 32'(sfug_pkg::RAM_BYTES_RST));
        send_block(region_lo, 64, 63, 1'b0);
        wait_drain();
        repeat (3) begin
            n = $urandom_range(2, 8);
            send_block(region_block(1), n, n - 1 - $urandom_range(0, 1), 1'b0);
            send_noise($urandom_range(1, 3), 1'b0);
        end
        sink_hold <= 300;
        send_block(region_block(1), 64, 63, 1'b0);
        wait_drain();
        write_reg(sfug_pkg::CFG_RAM_BASE, 32'd0);
        write_reg(sfug_pkg::CFG_RAM_BYTES, 32'h0100_0000);
        it = random_item();
        it.command       = 1'b1;
        it.flash_word    = $urandom_range(0, 1) ? image_pc : sfug_pkg::ALL_ONES;
        it.sp_slot_word  = $urandom_range(0, 1) ? image_sp : sfug_pkg::ALL_ONES;
        it.program_ok    = 1'b1;
        it.sp_program_ok = 1'b1;
        send_request(it);
        wait_drain();
    endtask

    // After completion words only compare; the last part runs without idling
    task automatic test_compare_mode();
        sfug_pkg::t_item it;
        it = random_item();
        it.command = 1'b1;
        send_request(it);
        send_block(region_block(0), 24, -1, 1'b1);
        wait_drain();
        jitter_on <= 1'b0;
        send_block(region_block(0), 6, 5, 1'b1);
        send_noise(8, 1'b1);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.command       = 1'b0;
        req_if.word_address  = '0;
        req_if.data_word     = '0;
        req_if.block_first   = 1'b0;
        req_if.block_last    = 1'b0;
        req_if.flash_word    = '0;
        req_if.sp_slot_word  = '0;
        req_if.erase_ok      = 1'b0;
        req_if.program_ok    = 1'b0;
        req_if.sp_program_ok = 1'b0;
        res_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.reg_index     = sfug_pkg::CFG_APP_BASE;
        cfg_if.wr_data       = '0;
        // SP at the very top of the RAM window used for the commit
        image_sp = 32'h0100_0000;
        image_pc = sfug_pkg::APP_BASE_RST + 32'd8 + 32'(2 * $urandom_range(0, 100)) + 32'd1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_block_rejects();
        test_wrong_length();
        test_config_extremes();
        test_image_update();
        test_compare_mode();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
src/sfug_pkg.sv
src/sfug_if.sv
src/sfug_eval.sv
src/safe_flash_update_guard.sv
src/sfug_checker.sv
tb/safe_flash_update_guard_tb.sv
